### hw/rtl/cbm_pkg.sv
// Shared types, codes and helpers of the cartridge bank mapper.
// Used by the access decoder, the top level and the testbench files.
`default_nettype none

package cbm_pkg;

  localparam int ROM_ADDR_BITS   = 19;
  localparam int WORK_RAM_BYTES  = 8192;
  localparam int TABLE_RAM_BYTES = 2048;
  localparam int WORK_IDX_BITS   = $clog2(WORK_RAM_BYTES);
  localparam int TABLE_IDX_BITS  = $clog2(TABLE_RAM_BYTES);
  localparam int SIZE_BITS       = 5;
  localparam int CFG_INDEX_BITS  = 1;

  localparam logic [SIZE_BITS-1:0] PRG_LOG2_MIN   = 5'd14;
  localparam logic [SIZE_BITS-1:0] CHR_LOG2_MIN   = 5'd11;
  localparam logic [SIZE_BITS-1:0] SIZE_LOG2_MAX  = 5'd19;
  localparam logic [SIZE_BITS-1:0] SIZE_LOG2_RST  = 5'd17;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRG_SIZE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHR_SIZE = 1'd1;

  typedef enum logic [2:0] {
    ACT_RAM_RD   = 3'd0,
    ACT_RAM_WR   = 3'd1,
    ACT_PRG_RD   = 3'd2,
    ACT_REG_WR   = 3'd3,
    ACT_PAT_RD   = 3'd4,
    ACT_TABLE_RD = 3'd5,
    ACT_TABLE_WR = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_PRG  = 2'd1,
    SEL_PAT  = 2'd2
  } rom_sel_t;

  // Where the read byte of an access comes from.
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_FF    = 2'd1,
    SRC_WORK  = 2'd2,
    SRC_TABLE = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    MIR_VERTICAL   = 2'd0,
    MIR_HORIZONTAL = 2'd1,
    MIR_SINGLE_LO  = 2'd2,
    MIR_SINGLE_HI  = 2'd3
  } mirror_t;

  typedef struct packed {
    logic [3:0][7:0] pattern;
    logic [1:0][7:0] table_bank;
    logic [3:0]      prog_page;
    mirror_t         mirror;
    logic            work_on;
    logic            rom_tables_on;
  } banks_t;

  typedef struct packed {
    logic                      wr_work;
    logic                      rd_work;
    logic [WORK_IDX_BITS-1:0]  work_idx;
    logic                      wr_table;
    logic                      rd_table;
    logic [TABLE_IDX_BITS-1:0] table_idx;
    src_t                      src;
    rom_sel_t                  sel;
    logic [ROM_ADDR_BITS-1:0]  rom_addr;
  } decision_t;

  // Address mask for a ROM of 2**lg bytes, lg clamped to [lo, 19].
  function automatic logic [ROM_ADDR_BITS-1:0] size_mask(input logic [SIZE_BITS-1:0] lg,
                                                          input logic [SIZE_BITS-1:0] lo);
    logic [SIZE_BITS-1:0] c;
    c = lg;
    if (c < lo) c = lo;
    if (c > SIZE_LOG2_MAX) c = SIZE_LOG2_MAX;
    return {ROM_ADDR_BITS{1'b1}} >> (SIZE_LOG2_MAX - c);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/cbm_req_if.sv
// Request channel: one bus access per transaction.
// Depends on cbm_pkg for nothing but keeps the field widths of the mapper.
`default_nettype none

interface cbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

`default_nettype wire

### hw/rtl/cbm_rsp_if.sv
// Response channel: one result per bus access.
// Widths follow the mapper's result fields.
`default_nettype none

interface cbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  rom_select;
  logic [18:0] rom_address;

  modport source (output valid, read_data, rom_select, rom_address, input ready);
  modport sink   (input valid, read_data, rom_select, rom_address, output ready);
endinterface

`default_nettype wire

### hw/rtl/cbm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`default_nettype none

module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cbm_decode.sv
// Access decoder: turns one bus access and the bank registers into RAM
// strobes, a read source and a translated ROM address. Uses cbm_pkg.
`default_nettype none

module cbm_decode
  import cbm_pkg::*;
(
  input  wire logic [2:0]           action,
  input  wire logic [15:0]          address,
  input  wire banks_t               banks,
  input  wire logic [SIZE_BITS-1:0] prg_size_log2,
  input  wire logic [SIZE_BITS-1:0] chr_size_log2,
  output decision_t                 dec
);

  logic [ROM_ADDR_BITS-1:0]  pmask;
  logic [ROM_ADDR_BITS-1:0]  cmask;
  logic [ROM_ADDR_BITS-1:0]  prg_off;
  logic [TABLE_IDX_BITS-1:0] mirrored;

  assign pmask = size_mask(prg_size_log2, PRG_LOG2_MIN);
  assign cmask = size_mask(chr_size_log2, CHR_LOG2_MIN);

  // The upper fixed window maps to the last 16 KiB bank of the ROM.
  always_comb begin
    case (address[15:14])
      2'b10:   prg_off = {1'b0, banks.prog_page, 14'd0};
      2'b11:   prg_off = {pmask[ROM_ADDR_BITS-1:14], 14'd0};
      default: prg_off = '0;
    endcase
  end

  always_comb begin
    case (banks.mirror)
      MIR_VERTICAL:   mirrored = {address[10], address[9:0]};
      MIR_HORIZONTAL: mirrored = {address[11], address[9:0]};
      MIR_SINGLE_LO:  mirrored = {1'b0, address[9:0]};
      default:        mirrored = {1'b1, address[9:0]};
    endcase
  end

  always_comb begin
    dec           = '0;
    dec.work_idx  = address[WORK_IDX_BITS-1:0];
    dec.table_idx = mirrored;
    dec.src       = SRC_ZERO;
    dec.sel       = SEL_NONE;
    case (action_t'(action))
      ACT_RAM_RD: begin
        dec.rd_work = banks.work_on;
        dec.src     = banks.work_on ? SRC_WORK : SRC_FF;
      end
      ACT_RAM_WR: begin
        dec.wr_work = banks.work_on;
      end
      ACT_PRG_RD: begin
        dec.sel      = SEL_PRG;
        dec.rom_addr = ({5'd0, address[13:0]} | prg_off) & pmask;
      end
      ACT_PAT_RD: begin
        dec.sel      = SEL_PAT;
        dec.rom_addr = ({8'd0, address[10:0]}
                        | {banks.pattern[address[12:11]], 11'd0}) & cmask;
      end
      ACT_TABLE_RD: begin
        if (!banks.rom_tables_on) begin
          dec.rd_table = 1'b1;
          dec.src      = SRC_TABLE;
        end else begin
          dec.sel      = SEL_PAT;
          dec.rom_addr = ({9'd0, mirrored[9:0]}
                          | {1'b0, banks.table_bank[mirrored[10]], 10'd0}) & cmask;
        end
      end
      ACT_TABLE_WR: begin
        dec.wr_table = !banks.rom_tables_on;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/cartridge_bank_mapper_rom_nametables_top.sv
// Bank-switching cartridge mapper with ROM nametables; one result per access.
// Each result passes the read stage (RAM read) and then the output register.
// Throughput: one access per cycle while rsp.ready holds, set by the single
// read port of each RAM. Reset: synchronous; afterwards both RAMs are cleared
// over 8192 indices; no request is taken meanwhile (config writes still accepted).
`default_nettype none

module cartridge_bank_mapper_rom_nametables_top
  import cbm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SIZE_BITS-1:0]      cfg_data,
  cbm_req_if.sink                        req,
  cbm_rsp_if.source                      rsp
);

  banks_t                   banks;
  logic [SIZE_BITS-1:0]     prg_size_log2;
  logic [SIZE_BITS-1:0]     chr_size_log2;
  decision_t                dec;
  logic                     accept;
  logic                     clearing;
  logic [WORK_IDX_BITS-1:0] clear_cnt;

  logic                     s1_valid;
  src_t                     s1_src;
  rom_sel_t                 s1_sel;
  logic [ROM_ADDR_BITS-1:0] s1_addr;
  logic                     s1_adv;

  logic                     o_valid;
  logic [7:0]               o_data;
  rom_sel_t                 o_sel;
  logic [ROM_ADDR_BITS-1:0] o_addr;

  logic [7:0]               work_rdata;
  logic [7:0]               table_rdata;
  logic [7:0]               s1_byte;

  cbm_decode u_decode (
    .action        (req.action),
    .address       (req.address),
    .banks         (banks),
    .prg_size_log2 (prg_size_log2),
    .chr_size_log2 (chr_size_log2),
    .dec           (dec)
  );

  assign s1_adv    = !o_valid || rsp.ready;
  assign req.ready = !clearing && (!s1_valid || s1_adv);
  assign accept    = req.valid && req.ready;

  // Both RAMs are swept together; the table RAM sees the low index bits.
  cbm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_work_ram (
    .clk     (clk),
    .wr_en   (clearing || (accept && dec.wr_work)),
    .wr_addr (clearing ? clear_cnt : dec.work_idx),
    .wr_data (clearing ? 8'd0 : req.write_data),
    .rd_en   (accept && dec.rd_work),
    .rd_addr (dec.work_idx),
    .rd_data (work_rdata)
  );

  cbm_ram #(.WIDTH(8), .DEPTH(TABLE_RAM_BYTES)) u_table_ram (
    .clk     (clk),
    .wr_en   (clearing || (accept && dec.wr_table)),
    .wr_addr (clearing ? clear_cnt[TABLE_IDX_BITS-1:0] : dec.table_idx),
    .wr_data (clearing ? 8'd0 : req.write_data),
    .rd_en   (accept && dec.rd_table),
    .rd_addr (dec.table_idx),
    .rd_data (table_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + 1'b1;
      if (&clear_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_size_log2 <= SIZE_LOG2_RST;
      chr_size_log2 <= SIZE_LOG2_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRG_SIZE: prg_size_log2 <= cfg_data;
        CFG_CHR_SIZE: chr_size_log2 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Register writes take effect at once, so the next access already sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      banks <= '0;
    end else if (accept && action_t'(req.action) == ACT_REG_WR && req.address[15]) begin
      case (req.address[14:12])
        3'b000, 3'b001, 3'b010, 3'b011: begin
          banks.pattern[req.address[13:12]] <= req.write_data;
        end
        3'b100, 3'b101: begin
          banks.table_bank[req.address[12]] <= {1'b1, req.write_data[6:0]};
        end
        3'b110: begin
          banks.mirror        <= mirror_t'(req.write_data[1:0]);
          banks.rom_tables_on <= req.write_data[4];
        end
        default: begin
          banks.prog_page <= req.write_data[3:0];
          banks.work_on   <= req.write_data[4];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src  <= dec.src;
      s1_sel  <= dec.sel;
      s1_addr <= dec.rom_addr;
    end
  end

  always_comb begin
    case (s1_src)
      SRC_FF:    s1_byte = 8'hff;
      SRC_WORK:  s1_byte = work_rdata;
      SRC_TABLE: s1_byte = table_rdata;
      default:   s1_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      o_data <= s1_byte;
      o_sel  <= s1_sel;
      o_addr <= s1_addr;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.read_data   = o_data;
  assign rsp.rom_select  = o_sel;
  assign rsp.rom_address = o_addr;

  a_no_req_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request taken during RAM clearing");

  a_held_stage_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && o_valid && !rsp.ready |=> s1_valid)
    else $error("held transaction dropped from read stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction missing from read stage");

  a_rom_read_no_byte: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_sel != SEL_NONE |-> o_data == 8'd0)
    else $error("ROM access carries a read byte");

  a_no_rom_zero_addr: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_sel == SEL_NONE |-> o_addr == '0)
    else $error("ROM address set without ROM access");

endmodule

`default_nettype wire

### tb/cbm_access_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the cartridge bank mapper: predicts the result of every request
// transaction from its own bank registers and RAM copies, and compares responses.
// Depends on cbm_pkg and the cbm_req_if / cbm_rsp_if channel interfaces.

module cbm_access_checker
  import cbm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SIZE_BITS-1:0]      cfg_data,
  cbm_req_if                        req,
  cbm_rsp_if                        rsp,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [7:0]               read_data;
    rom_sel_t                 rom_select;
    logic [ROM_ADDR_BITS-1:0] rom_address;
  } access_result_t;

  logic [7:0]           pat_bank [4];
  logic [7:0]           nt_bank [2];
  logic [3:0]           prog_page;
  mirror_t              mirroring;
  logic                 wram_enabled;
  logic                 nt_from_rom;
  logic [7:0]           wram [WORK_RAM_BYTES];
  logic [7:0]           ntram [TABLE_RAM_BYTES];
  logic [SIZE_BITS-1:0] prg_lg;
  logic [SIZE_BITS-1:0] chr_lg;
  access_result_t       awaited_results [$];

  // Byte mask of a ROM of 2**lg bytes, with lg held within [lo, 19].
  function automatic logic [31:0] rom_mask(input logic [SIZE_BITS-1:0] lg,
                                           input logic [SIZE_BITS-1:0] lo);
    int bits;
    bits = (lg < lo) ? int'(lo) : (lg > SIZE_LOG2_MAX) ? int'(SIZE_LOG2_MAX) : int'(lg);
    return (32'd1 << bits) - 32'd1;
  endfunction

  function automatic logic [10:0] mirrored(input logic [15:0] a);
    case (mirroring)
      MIR_VERTICAL:   return a[10:0];
      MIR_HORIZONTAL: return {a[11], a[9:0]};
      MIR_SINGLE_LO:  return {1'b0, a[9:0]};
      default:        return {1'b1, a[9:0]};
    endcase
  endfunction

  // Applies one bus access to the local state and returns the result it gives.
  function automatic access_result_t predict_access(input logic [2:0]  act,
                                                    input logic [15:0] a,
                                                    input logic [7:0]  d);
    access_result_t r;
    logic [31:0]    pmask;
    logic [31:0]    cmask;
    logic [31:0]    offset;
    logic [31:0]    raddr;
    logic [10:0]    m;
    r     = '0;
    raddr = '0;
    pmask = rom_mask(prg_lg, PRG_LOG2_MIN);
    cmask = rom_mask(chr_lg, CHR_LOG2_MIN);
    case (act)
      ACT_RAM_RD: r.read_data = wram_enabled ? wram[a[12:0]] : 8'hff;
      ACT_RAM_WR: if (wram_enabled) wram[a[12:0]] = d;
      ACT_PRG_RD: begin
        offset = '0;
        if (a[15:14] == 2'b10) offset = {28'd0, prog_page} << 14;
        else if (a[15:14] == 2'b11) offset = pmask + 32'd1 - 32'h4000;
        raddr = ({18'd0, a[13:0]} | offset) & pmask;
        r.rom_select = SEL_PRG;
      end
      ACT_REG_WR: begin
        case (a[15:12])
          4'h8, 4'h9, 4'ha, 4'hb: pat_bank[a[13:12]] = d;
          4'hc, 4'hd: nt_bank[a[12]] = {1'b1, d[6:0]};
          4'he: begin
            mirroring   = mirror_t'(d[1:0]);
            nt_from_rom = d[4];
          end
          4'hf: begin
            prog_page    = d[3:0];
            wram_enabled = d[4];
          end
          default: ;
        endcase
      end
      ACT_PAT_RD: begin
        raddr = (({24'd0, pat_bank[a[12:11]]} << 11) | {21'd0, a[10:0]}) & cmask;
        r.rom_select = SEL_PAT;
      end
      ACT_TABLE_RD: begin
        m = mirrored(a);
        if (!nt_from_rom) begin
          r.read_data = ntram[m];
        end else begin
          raddr = (({24'd0, nt_bank[m[10]]} << 10) | {22'd0, m[9:0]}) & cmask;
          r.rom_select = SEL_PAT;
        end
      end
      ACT_TABLE_WR: if (!nt_from_rom) ntram[mirrored(a)] = d;
      default: ;
    endcase
    r.rom_address = raddr[ROM_ADDR_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (rst) begin
      foreach (pat_bank[i]) pat_bank[i] = '0;
      foreach (nt_bank[i]) nt_bank[i] = '0;
      foreach (wram[i]) wram[i] = '0;
      foreach (ntram[i]) ntram[i] = '0;
      prog_page    = '0;
      mirroring    = MIR_VERTICAL;
      wram_enabled = 1'b0;
      nt_from_rom  = 1'b0;
      prg_lg       = SIZE_LOG2_RST;
      chr_lg       = SIZE_LOG2_RST;
      errors       = 0;
      awaited_results.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_PRG_SIZE) prg_lg = cfg_data;
        else if (cfg_index == CFG_CHR_SIZE) chr_lg = cfg_data;
      end
      // Retire the oldest expectation before queueing one for a new request.
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.read_data, rom_sel_t'(rsp.rom_select), rsp.rom_address};
        if (awaited_results.size() == 0) begin
          $error("response transaction with no access outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            errors++;
          end
          if (got.rom_select !== want.rom_select) begin
            $error("rom_select: expected %0d, got %0d", want.rom_select, got.rom_select);
            errors++;
          end
          if (got.rom_address !== want.rom_address) begin
            $error("rom_address: expected %0h, got %0h", want.rom_address,
                   got.rom_address);
            errors++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(predict_access(req.action, req.address, req.write_data));
      pending <= awaited_results.size();
    end
  end

endmodule

### tb/tb_cartridge_bank_mapper_rom_nametables_top.sv
`timescale 1ns / 1ps
// Top of the bank mapper testbench: clock, reset, size settings and bus accesses,
// directed then random, under several idling patterns. Depends on cbm_pkg, the
// channel interfaces, the mapper top and cbm_access_checker.

module tb_cartridge_bank_mapper_rom_nametables_top;
  import cbm_pkg::*;

  localparam logic [2:0] ACT_UNUSED      = 3'd7;
  localparam int         PHASES          = 6;
  localparam int         ITEMS_PER_PHASE = 110;
  localparam int         LIMIT_CYCLES    = 400000;

  // Program and pattern sizes per phase, including out-of-range values.
  localparam logic [SIZE_BITS-1:0] PRG_STEPS [PHASES] = '{5'd14, 5'd18, 5'd31, 5'd0,
                                                           5'd16, 5'd19};
  localparam logic [SIZE_BITS-1:0] CHR_STEPS [PHASES] = '{5'd11, 5'd19, 5'd0, 5'd31,
                                                           5'd15, 5'd12};

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [SIZE_BITS-1:0]      cfg_data;
  int                        errors;
  int                        pending;
  int                        cycles    = 0;
  int                        idle_pct  = 0;
  int                        stall_pct = 0;

  cbm_req_if req ();
  cbm_rsp_if rsp ();

  cartridge_bank_mapper_rom_nametables_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  cbm_access_checker u_access_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("cartridge_bank_mapper_rom_nametables_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) rsp.ready <= ($urandom_range(99) >= stall_pct);

  // Holds the access on the channel until its transaction completes; returns in
  // the time step of that edge without touching valid.
  task automatic send_access(input logic [2:0] act, input logic [15:0] a,
                             input logic [7:0] d);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.address    <= a;
    req.write_data <= d;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_sizes(input logic [SIZE_BITS-1:0] prg,
                             input logic [SIZE_BITS-1:0] chr);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PRG_SIZE;
    cfg_data  <= prg;
    @(posedge clk);
    cfg_index <= CFG_CHR_SIZE;
    cfg_data  <= chr;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_access();
    logic [2:0]  act;
    logic [15:0] a;
    logic [7:0]  d;
    int          roll;
    roll = $urandom_range(99);
    a    = 16'($urandom);
    d    = 8'($urandom);
    if (roll < 14) act = ACT_RAM_RD;
    else if (roll < 26) act = ACT_RAM_WR;
    else if (roll < 38) act = ACT_PRG_RD;
    else if (roll < 54) act = ACT_REG_WR;
    else if (roll < 66) act = ACT_PAT_RD;
    else if (roll < 82) act = ACT_TABLE_RD;
    else if (roll < 96) act = ACT_TABLE_WR;
    else act = ACT_UNUSED;
    // Most RAM traffic goes to a small pool of locations so that reads find
    // bytes written earlier.
    if ((act == ACT_RAM_RD || act == ACT_RAM_WR || act == ACT_TABLE_RD ||
         act == ACT_TABLE_WR) && $urandom_range(99) < 60)
      a = {a[15:10], 6'd0, a[3:0]};
    if (act == ACT_REG_WR) begin
      if ($urandom_range(99) < 88) a[15] = 1'b1;
      if (a[15:12] == 4'hf) d[4] = ($urandom_range(3) != 0);
      if (a[15:12] == 4'he) d[4] = ($urandom_range(9) < 3);
    end
    send_access(act, a, d);
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= CFG_PRG_SIZE;
    cfg_data       <= SIZE_LOG2_RST;
    req.valid      <= 1'b0;
    req.action     <= ACT_RAM_RD;
    req.address    <= '0;
    req.write_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed accesses with the reset sizes; work RAM starts disabled.
    send_access(ACT_RAM_RD, 16'h6000, 8'h00);
    send_access(ACT_RAM_WR, 16'h6001, 8'haa);
    send_access(ACT_REG_WR, 16'h7fff, 8'hff);
    send_access(ACT_REG_WR, 16'hf000, 8'h1f);
    send_access(ACT_RAM_WR, 16'hffff, 8'hff);
    send_access(ACT_RAM_RD, 16'h7fff, 8'h00);
    send_access(ACT_RAM_RD, 16'h6001, 8'h00);
    send_access(ACT_PRG_RD, 16'h0000, 8'h00);
    send_access(ACT_PRG_RD, 16'hbfff, 8'h00);
    send_access(ACT_PRG_RD, 16'hc000, 8'h00);
    send_access(ACT_REG_WR, 16'h8000, 8'hff);
    send_access(ACT_REG_WR, 16'hbfff, 8'h80);
    send_access(ACT_PAT_RD, 16'h07ff, 8'h00);
    send_access(ACT_PAT_RD, 16'hffff, 8'h00);
    send_access(ACT_TABLE_WR, 16'h2c00, 8'h5a);
    send_access(ACT_TABLE_RD, 16'h2400, 8'h00);
    send_access(ACT_REG_WR, 16'he001, 8'h01);
    send_access(ACT_TABLE_RD, 16'h2800, 8'h00);
    send_access(ACT_REG_WR, 16'hc000, 8'hff);
    send_access(ACT_REG_WR, 16'hdfff, 8'h00);
    send_access(ACT_REG_WR, 16'he000, 8'h13);
    send_access(ACT_TABLE_RD, 16'h23ff, 8'h00);
    send_access(ACT_TABLE_WR, 16'h2000, 8'h11);
    send_access(ACT_UNUSED, 16'hffff, 8'hff);
    send_access(ACT_REG_WR, 16'he000, 8'h02);
    send_access(ACT_TABLE_RD, 16'h2000, 8'h00);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_sizes(PRG_STEPS[p], CHR_STEPS[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      repeat (ITEMS_PER_PHASE) random_access();
      drain();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("cartridge_bank_mapper_rom_nametables_top: match");
    end else begin
      $display("cartridge_bank_mapper_rom_nametables_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_req_if.sv
hw/rtl/cbm_rsp_if.sv
hw/rtl/cbm_ram.sv
hw/rtl/cbm_decode.sv
hw/rtl/cartridge_bank_mapper_rom_nametables_top.sv
tb/cbm_access_checker.sv
tb/tb_cartridge_bank_mapper_rom_nametables_top.sv
